// ===== rtl/core/sdc_pkg.sv =====
package sdc_pkg;

  localparam int KEY_W   = 50;
  localparam int TIME_W  = 48;
  localparam int STALE_W = 16;
  localparam int SLOT_W  = 3;
  localparam int OUT_W   = 3;

  localparam logic [15:0] APPEAR_KEYBOARD    = 16'h03C1;
  localparam logic [15:0] APPEAR_HID_GENERIC = 16'h03C0;
  localparam logic [15:0] STALE_RESET        = 16'd3000;

  localparam logic REQ_OBSERVE = 1'b0;
  localparam logic REQ_CLEAR   = 1'b1;

  typedef enum logic [OUT_W-1:0] {
    OC_HIT     = 3'd0,
    OC_FREE    = 3'd1,
    OC_STALE   = 3'd2,
    OC_OLDEST  = 3'd3,
    OC_CLEARED = 3'd4
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // flags: [0] connectable, [1] hid, [2] keyboard
  typedef struct packed {
    logic              vld;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
    logic [2:0]        obs;
    logic              hit;
    logic [2:0]        hit_flags;
    logic              free_f;
    logic              stale_f;
    logic              old_f;
    logic [TIME_W-1:0] old_t;
  } scan_rec_t;

  typedef struct packed {
    logic              en;
    logic              clr;
    logic              claim;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
    logic [2:0]        obs;
  } wr_cmd_t;

endpackage

// ===== rtl/core/scan_device_cache_with_stale_eviction_top.sv =====
// Scan device cache: a table of ENTRIES advertising devices keyed by
// (address kind, 48-bit address), held in a row of cells.
// Input channel in_*: in_valid/in_stall, one request per transfer. An observe
// request looks the key up; a clear request empties the table.
// Result channel out_*: out_valid/out_stall, one result per request, holding
// slot, outcome, sticky flags and the qualifies bit.
// Config channel cfg_*: cfg_valid/cfg_ready, writes stale_time_ms; always ready.
// An observe request walks the cell row one cell per cycle; then its scan is
// captured in the tail register, and its result is written to the output
// register once that register is free. The next request is taken only after.
// A clear request skips the cell row and goes straight to its result.
// One request is in flight at a time; in_stall is high while it is scanned or
// its result waits for the output register. When the receiver stalls, the
// result register holds, and the finished request waits for it with the table
// still unwritten.
// Reset empties the table and sets stale_time_ms to 3000.
module scan_device_cache_with_stale_eviction_top #(
  parameter int ENTRIES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_stale_time_ms,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [1:0]  in_addr_kind,
  input  logic [47:0] in_dev_addr,
  input  logic [47:0] in_now_ms,
  input  logic        in_adv_connectable,
  input  logic        in_hid_uuid_seen,
  input  logic        in_appearance_valid,
  input  logic [15:0] in_appearance_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_slot_index,
  output logic [2:0]  out_outcome,
  output logic        out_flag_connectable,
  output logic        out_flag_hid,
  output logic        out_flag_keyboard,
  output logic        out_qualifies
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  sdc_pkg::state_t            state_r, state_nxt;
  logic [15:0]                stale_r;

  sdc_pkg::scan_rec_t         rec_w       [ENTRIES+1];
  logic [IW-1:0]              hit_idx_w   [ENTRIES+1];
  logic [IW-1:0]              free_idx_w  [ENTRIES+1];
  logic [IW-1:0]              stale_idx_w [ENTRIES+1];
  logic [IW-1:0]              old_idx_w   [ENTRIES+1];

  sdc_pkg::scan_rec_t         tail_r;
  logic [IW-1:0]              tail_hit_idx_r, tail_free_idx_r;
  logic [IW-1:0]              tail_stale_idx_r, tail_old_idx_r;
  logic                       tail_clr_r;

  logic                       out_valid_r;
  logic [2:0]                 out_slot_r, out_outcome_r, out_flags_r;

  logic                       in_xfer;
  logic                       out_free;
  logic                       capture;
  logic                       finish;
  logic [2:0]                 obs_in;
  logic                       kbd_code;

  sdc_pkg::wr_cmd_t           wr;
  logic [IW-1:0]              slot;
  sdc_pkg::outcome_t          outcome;
  logic [2:0]                 flags_res;
  logic [IW+2:0]              slot_ext;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_r <= sdc_pkg::STALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      stale_r <= cfg_stale_time_ms;
    end
  end

  assign in_stall = (state_r != sdc_pkg::ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign kbd_code = (in_appearance_code == sdc_pkg::APPEAR_KEYBOARD) ||
                    (in_appearance_code == sdc_pkg::APPEAR_HID_GENERIC);
  assign obs_in   = {in_appearance_valid && kbd_code, in_hid_uuid_seen, in_adv_connectable};

  // head of the cell row: the request enters cell 0 on its transfer
  always_comb begin
    rec_w[0]           = '0;
    rec_w[0].vld       = in_xfer && (in_req_type == sdc_pkg::REQ_OBSERVE);
    rec_w[0].key       = {in_addr_kind, in_dev_addr};
    rec_w[0].now       = in_now_ms;
    rec_w[0].obs       = obs_in;
    hit_idx_w[0]       = '0;
    free_idx_w[0]      = '0;
    stale_idx_w[0]     = '0;
    old_idx_w[0]       = '0;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    sdc_cell #(
      .IW  (IW),
      .IDX (g)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .stale_time  (stale_r),
      .rec_i       (rec_w[g]),
      .hit_idx_i   (hit_idx_w[g]),
      .free_idx_i  (free_idx_w[g]),
      .stale_idx_i (stale_idx_w[g]),
      .old_idx_i   (old_idx_w[g]),
      .rec_o       (rec_w[g+1]),
      .hit_idx_o   (hit_idx_w[g+1]),
      .free_idx_o  (free_idx_w[g+1]),
      .stale_idx_o (stale_idx_w[g+1]),
      .old_idx_o   (old_idx_w[g+1]),
      .wr_i        (wr),
      .wr_idx_i    (slot)
    );
  end

  assign capture = (state_r == sdc_pkg::ST_SCAN) && rec_w[ENTRIES].vld;
  assign finish  = (state_r == sdc_pkg::ST_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (capture || in_xfer) begin
      tail_r           <= rec_w[ENTRIES];
      tail_hit_idx_r   <= hit_idx_w[ENTRIES];
      tail_free_idx_r  <= free_idx_w[ENTRIES];
      tail_stale_idx_r <= stale_idx_w[ENTRIES];
      tail_old_idx_r   <= old_idx_w[ENTRIES];
      tail_clr_r       <= in_xfer && (in_req_type == sdc_pkg::REQ_CLEAR);
    end
  end

  // replacement choice: hit, then first free, then first stale, then oldest
  always_comb begin
    if (tail_r.hit) begin
      slot    = tail_hit_idx_r;
      outcome = sdc_pkg::OC_HIT;
    end else if (tail_r.free_f) begin
      slot    = tail_free_idx_r;
      outcome = sdc_pkg::OC_FREE;
    end else if (tail_r.stale_f) begin
      slot    = tail_stale_idx_r;
      outcome = sdc_pkg::OC_STALE;
    end else begin
      slot    = tail_old_idx_r;
      outcome = sdc_pkg::OC_OLDEST;
    end
    flags_res = (tail_r.hit ? tail_r.hit_flags : 3'b000) | tail_r.obs;

    wr       = '0;
    wr.en    = finish && !tail_clr_r;
    wr.clr   = finish && tail_clr_r;
    wr.claim = !tail_r.hit;
    wr.key   = tail_r.key;
    wr.now   = tail_r.now;
    wr.obs   = tail_r.obs;
  end

  assign slot_ext = {3'b000, slot};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sdc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_req_type == sdc_pkg::REQ_CLEAR) ? sdc_pkg::ST_DONE
                                                          : sdc_pkg::ST_SCAN;
        end
      end
      sdc_pkg::ST_SCAN: begin
        if (capture) begin
          state_nxt = sdc_pkg::ST_DONE;
        end
      end
      sdc_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = sdc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sdc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (tail_clr_r) begin
        out_slot_r    <= '0;
        out_outcome_r <= sdc_pkg::OC_CLEARED;
        out_flags_r   <= 3'b000;
      end else begin
        out_slot_r    <= slot_ext[2:0];
        out_outcome_r <= outcome;
        out_flags_r   <= flags_res;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_slot_index       = out_slot_r;
  assign out_outcome          = out_outcome_r;
  assign out_flag_connectable = out_flags_r[0];
  assign out_flag_hid         = out_flags_r[1];
  assign out_flag_keyboard    = out_flags_r[2];
  assign out_qualifies        = &out_flags_r;

endmodule

// ===== rtl/core/sdc_cell.sv =====
module sdc_cell #(
  parameter int IW  = 3,
  parameter int IDX = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [sdc_pkg::STALE_W-1:0]  stale_time,
  input  sdc_pkg::scan_rec_t           rec_i,
  input  logic [IW-1:0]                hit_idx_i,
  input  logic [IW-1:0]                free_idx_i,
  input  logic [IW-1:0]                stale_idx_i,
  input  logic [IW-1:0]                old_idx_i,
  output sdc_pkg::scan_rec_t           rec_o,
  output logic [IW-1:0]                hit_idx_o,
  output logic [IW-1:0]                free_idx_o,
  output logic [IW-1:0]                stale_idx_o,
  output logic [IW-1:0]                old_idx_o,
  input  sdc_pkg::wr_cmd_t             wr_i,
  input  logic [IW-1:0]                wr_idx_i
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic                              valid_r;
  logic [sdc_pkg::KEY_W-1:0]         key_r;
  logic [sdc_pkg::TIME_W-1:0]        last_r;
  logic [2:0]                        flags_r;

  sdc_pkg::scan_rec_t                rec_nxt, rec_r;
  logic [IW-1:0]                     hit_idx_nxt, free_idx_nxt, stale_idx_nxt, old_idx_nxt;
  logic [IW-1:0]                     hit_idx_r, free_idx_r, stale_idx_r, old_idx_r;

  logic                              match;
  logic                              not_back;
  logic [sdc_pkg::TIME_W-1:0]        idle_time;
  logic                              is_stale;
  logic                              wr_me;

  assign match     = valid_r && (key_r == rec_i.key);
  assign not_back  = rec_i.now >= last_r;
  assign idle_time = rec_i.now - last_r;
  assign is_stale  = not_back &&
                     (idle_time >= {{(sdc_pkg::TIME_W-sdc_pkg::STALE_W){1'b0}}, stale_time});

  always_comb begin
    rec_nxt       = rec_i;
    hit_idx_nxt   = hit_idx_i;
    free_idx_nxt  = free_idx_i;
    stale_idx_nxt = stale_idx_i;
    old_idx_nxt   = old_idx_i;
    if (rec_i.vld && !rec_i.hit) begin
      if (match) begin
        rec_nxt.hit       = 1'b1;
        rec_nxt.hit_flags = flags_r;
        hit_idx_nxt       = MY_IDX;
      end else if (!valid_r) begin
        if (!rec_i.free_f) begin
          rec_nxt.free_f = 1'b1;
          free_idx_nxt   = MY_IDX;
        end
      end else begin
        if (!rec_i.stale_f && is_stale) begin
          rec_nxt.stale_f = 1'b1;
          stale_idx_nxt   = MY_IDX;
        end
        // strict less-than keeps the lowest index on ties
        if (!rec_i.old_f || (last_r < rec_i.old_t)) begin
          rec_nxt.old_f = 1'b1;
          rec_nxt.old_t = last_r;
          old_idx_nxt   = MY_IDX;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r.vld <= 1'b0;
    end else begin
      rec_r <= rec_nxt;
    end
    hit_idx_r   <= hit_idx_nxt;
    free_idx_r  <= free_idx_nxt;
    stale_idx_r <= stale_idx_nxt;
    old_idx_r   <= old_idx_nxt;
  end

  assign rec_o       = rec_r;
  assign hit_idx_o   = hit_idx_r;
  assign free_idx_o  = free_idx_r;
  assign stale_idx_o = stale_idx_r;
  assign old_idx_o   = old_idx_r;

  assign wr_me = wr_i.en && (wr_idx_i == MY_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_i.clr) begin
      valid_r <= 1'b0;
    end else if (wr_me && wr_i.claim) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_me) begin
      last_r <= wr_i.now;
      if (wr_i.claim) begin
        key_r   <= wr_i.key;
        flags_r <= wr_i.obs;
      end else begin
        flags_r <= flags_r | wr_i.obs;
      end
    end
  end

endmodule
